// ===== design/pcg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared constants, control types and the XSH-RR output function of the
// PCG32 generator.
// ----------------------------------------------------------------------------
package pcg_pkg;

  localparam logic [63:0] PCG_MULT      = 64'd6364136223846793005;
  localparam logic [63:0] PCG_STATE_RST = 64'h853c49e6748fea9b;
  localparam logic [63:0] PCG_INC_RST   = 64'hda3e39cb94b95bdb;

  localparam int unsigned XS_SHIFT  = 18;
  localparam int unsigned OUT_LSB   = 27;
  localparam int unsigned ROT_LSB   = 59;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SEED_ADD
  } seq_state_t;

  typedef enum logic [1:0] {
    ADD_A_PROD,
    ADD_A_ACC,
    ADD_A_STATE
  } add_a_sel_t;

  typedef enum logic [1:0] {
    ADD_B_INC,
    ADD_B_PROD_HI,
    ADD_B_SEED
  } add_b_sel_t;

  typedef struct packed {
    logic       load_seed;
    logic       prod_en;
    logic       a_hi;
    logic       m_hi;
    add_a_sel_t add_a_sel;
    add_b_sel_t add_b_sel;
    logic       acc_we;
    logic       state_we;
  } dp_ctrl_t;

  // XSH-RR output of a state word, top bit cleared
  function automatic logic [30:0] xsh_rr(input logic [63:0] old);
    logic [63:0] xs;
    logic [31:0] mixed;
    logic [4:0]  rot;
    logic [63:0] dbl;
    xs    = (old >> XS_SHIFT) ^ old;
    mixed = xs[OUT_LSB +: 32];
    rot   = old[ROT_LSB +: 5];
    dbl   = {mixed, mixed} >> rot;
    return dbl[30:0];
  endfunction

endpackage

// ===== design/pcg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg_dp
// Datapath: LCG state and increment, one registered 32x32 multiplier and
// one 64-bit adder shared by every partial product and the seed add.
// ----------------------------------------------------------------------------
module pcg_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  pcg_pkg::dp_ctrl_t ctrl,
  input  logic [63:0]      in_seed_state,
  input  logic [63:0]      in_seed_sequence,
  output logic [63:0]      lcg_state
);

  logic [63:0] lcg_state_r, lcg_state_nxt;
  logic [63:0] lcg_inc_r, lcg_inc_nxt;
  logic [63:0] seed_r, seed_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] acc_r, acc_nxt;

  logic [31:0] a_half;
  logic [31:0] m_half;
  logic [63:0] mul_res;
  logic [63:0] add_a;
  logic [63:0] add_b;
  logic [63:0] sum;

  assign a_half  = ctrl.a_hi ? lcg_state_r[63:32] : lcg_state_r[31:0];
  assign m_half  = ctrl.m_hi ? pcg_pkg::PCG_MULT[63:32] : pcg_pkg::PCG_MULT[31:0];
  assign mul_res = {32'h0, a_half} * {32'h0, m_half};

  always_comb begin
    unique case (ctrl.add_a_sel)
      pcg_pkg::ADD_A_PROD:  add_a = prod_r;
      pcg_pkg::ADD_A_ACC:   add_a = acc_r;
      pcg_pkg::ADD_A_STATE: add_a = lcg_state_r;
      default:              add_a = prod_r;
    endcase
    unique case (ctrl.add_b_sel)
      pcg_pkg::ADD_B_INC:     add_b = lcg_inc_r;
      pcg_pkg::ADD_B_PROD_HI: add_b = {prod_r[31:0], 32'h0};
      pcg_pkg::ADD_B_SEED:    add_b = seed_r;
      default:                add_b = lcg_inc_r;
    endcase
  end

  assign sum = add_a + add_b;

  always_comb begin
    lcg_state_nxt = lcg_state_r;
    lcg_inc_nxt   = lcg_inc_r;
    seed_nxt      = seed_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    if (ctrl.load_seed) begin
      lcg_state_nxt = 64'h0;
      lcg_inc_nxt   = {in_seed_sequence[62:0], 1'b1};
      seed_nxt      = in_seed_state;
    end else if (ctrl.state_we) begin
      lcg_state_nxt = sum;
    end
    if (ctrl.prod_en) begin
      prod_nxt = mul_res;
    end
    if (ctrl.acc_we) begin
      acc_nxt = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcg_state_r <= pcg_pkg::PCG_STATE_RST;
      lcg_inc_r   <= pcg_pkg::PCG_INC_RST;
    end else begin
      lcg_state_r <= lcg_state_nxt;
      lcg_inc_r   <= lcg_inc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seed_r <= seed_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign lcg_state = lcg_state_r;

endmodule

// ===== design/pcg_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg_seq
// Sequencer: walks the shared multiplier through the three partial products
// of each LCG step and orders the two steps and the add of a seed item.
// ----------------------------------------------------------------------------
module pcg_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  input  logic              out_free,
  output logic              busy,
  output logic              out_load,
  output pcg_pkg::dp_ctrl_t ctrl
);

  pcg_pkg::seq_state_t state_r, state_nxt;
  logic                is_seed_r, is_seed_nxt;
  logic                second_r, second_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pcg_pkg::S_IDLE;
      is_seed_r <= 1'b0;
      second_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      is_seed_r <= is_seed_nxt;
      second_r  <= second_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    is_seed_nxt    = is_seed_r;
    second_nxt     = second_r;
    out_load       = 1'b0;
    ctrl.load_seed = 1'b0;
    ctrl.prod_en   = 1'b0;
    ctrl.a_hi      = 1'b0;
    ctrl.m_hi      = 1'b0;
    ctrl.add_a_sel = pcg_pkg::ADD_A_PROD;
    ctrl.add_b_sel = pcg_pkg::ADD_B_INC;
    ctrl.acc_we    = 1'b0;
    ctrl.state_we  = 1'b0;
    unique case (state_r)
      pcg_pkg::S_IDLE: begin
        if (in_valid) begin
          ctrl.load_seed = in_action;
          is_seed_nxt    = in_action;
          second_nxt     = 1'b0;
          state_nxt      = pcg_pkg::S_MUL0;
        end
      end
      pcg_pkg::S_MUL0: begin
        // low x low
        ctrl.prod_en = 1'b1;
        state_nxt    = pcg_pkg::S_MUL1;
      end
      pcg_pkg::S_MUL1: begin
        ctrl.add_a_sel = pcg_pkg::ADD_A_PROD;
        ctrl.add_b_sel = pcg_pkg::ADD_B_INC;
        ctrl.acc_we    = 1'b1;
        ctrl.prod_en   = 1'b1;
        ctrl.a_hi      = 1'b1;
        state_nxt      = pcg_pkg::S_MUL2;
      end
      pcg_pkg::S_MUL2: begin
        ctrl.add_a_sel = pcg_pkg::ADD_A_ACC;
        ctrl.add_b_sel = pcg_pkg::ADD_B_PROD_HI;
        ctrl.acc_we    = 1'b1;
        ctrl.prod_en   = 1'b1;
        ctrl.m_hi      = 1'b1;
        state_nxt      = pcg_pkg::S_MUL3;
      end
      pcg_pkg::S_MUL3: begin
        ctrl.add_a_sel = pcg_pkg::ADD_A_ACC;
        ctrl.add_b_sel = pcg_pkg::ADD_B_PROD_HI;
        if (is_seed_r) begin
          ctrl.state_we = 1'b1;
          state_nxt     = second_r ? pcg_pkg::S_IDLE : pcg_pkg::S_SEED_ADD;
        end else if (out_free) begin
          // commit only once the output register can take the item
          ctrl.state_we = 1'b1;
          out_load      = 1'b1;
          state_nxt     = pcg_pkg::S_IDLE;
        end
      end
      pcg_pkg::S_SEED_ADD: begin
        ctrl.add_a_sel = pcg_pkg::ADD_A_STATE;
        ctrl.add_b_sel = pcg_pkg::ADD_B_SEED;
        ctrl.state_we  = 1'b1;
        second_nxt     = 1'b1;
        state_nxt      = pcg_pkg::S_MUL0;
      end
      default: begin
        state_nxt = pcg_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != pcg_pkg::S_IDLE);

  a_state_we_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.state_we |-> (state_r == pcg_pkg::S_MUL3 || state_r == pcg_pkg::S_SEED_ADD))
    else $error("state written outside a commit phase");

  a_second_only_seed: assert property (@(posedge clk) disable iff (!rst_n)
    second_r && busy |-> is_seed_r)
    else $error("second step flagged on a next item");

  a_hold_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcg_pkg::S_MUL3 && !is_seed_r && !out_free) |=>
      (state_r == pcg_pkg::S_MUL3))
    else $error("next item left the last phase without an output slot");

endmodule

// ===== design/pcg32_random_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg32_random_generator_top
// PCG32 (XSH-RR) generator with a next/seed item interface.
// ----------------------------------------------------------------------------
// One item is in work at a time; in_stall is high while it is. Each LCG step
// runs on a single 32x32 multiplier and one 64-bit adder through the states
// S_MUL0 to S_MUL3 (three partial products of the 64-bit low-half multiply,
// then the final add). A next item occupies the block from the accept cycle
// through S_MUL3, and longer while the output register is still held by
// out_stall; a seed item runs two steps plus the seed add and produces no
// result. The result register lets an item be accepted while the previous
// result is still waiting to be taken.
// ----------------------------------------------------------------------------
module pcg32_random_generator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [63:0] in_seed_state,
  input  logic [63:0] in_seed_sequence,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_random_value
);

  pcg_pkg::dp_ctrl_t ctrl;
  logic              busy;
  logic              out_load;
  logic              out_free;
  logic [63:0]       lcg_state;

  logic              out_valid_r, out_valid_nxt;
  logic [30:0]       out_value_r, out_value_nxt;

  pcg_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .out_free  (out_free),
    .busy      (busy),
    .out_load  (out_load),
    .ctrl      (ctrl)
  );

  pcg_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .in_seed_state    (in_seed_state),
    .in_seed_sequence (in_seed_sequence),
    .lcg_state        (lcg_state)
  );

  assign in_stall = busy;
  assign out_free = !out_valid_r || !out_stall;

  // output taken from the state before it advances on the same edge
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = pcg_pkg::xsh_rr(lcg_state);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

endmodule
